// ===== design/rhsl_pkg.sv =====
//----------------------------------------------------------------------------
// rhsl_pkg: shared types and constants for the RGB to HSL converter
// Channel and divider widths and the classified item that travels from the
// front end through the queue to the divider back end.
//----------------------------------------------------------------------------
package rhsl_pkg;

  // one color channel
  localparam int unsigned ChanW  = 8;
  // dividend width: 512*n + 6*d with n up to 6*255
  localparam int unsigned NumW   = 20;
  // divisor width: 12*d with d up to 255
  localparam int unsigned DenW   = 12;
  // quotient width: results reach 256 before the clamp
  localparam int unsigned QuoW   = 9;
  // sextant numerator width, up to 6*255
  localparam int unsigned SxtW   = 11;
  // log2 of 2*256: doubles the dividend for round half up and scales by 256
  localparam int unsigned ScaleSh = 9;

  // classified item, ready for the two dividers
  typedef struct packed {
    logic [NumW-1:0]  hue_num;
    logic [DenW-1:0]  hue_den;
    logic [NumW-1:0]  sat_num;
    logic [DenW-1:0]  sat_den;
    logic             grey;
    logic [ChanW-1:0] lightness;
    logic [ChanW-1:0] alpha;
  } rhsl_item_t;

endpackage

// ===== design/rgb_to_hsl_8bit.sv =====
//----------------------------------------------------------------------------
// rgb_to_hsl_8bit: packed RGBA pixel to 8-bit hue, saturation, lightness
// Front end classifies each pixel, a short queue decouples it from the
// divider back end, which produces one result per accepted pixel.
//----------------------------------------------------------------------------
// Usage: raise start with a pixel whenever busy is low; the pixel is taken
// at that clock edge, and one pixel per clock can be streamed. Each result
// appears on the output ports for a single cycle with valid_o high, in input
// order, after two classify stages, the queue register, the nine-stage
// divider pipelines (one quotient bit per stage) and the output register.
// Results cannot be held off; since the back end drains every cycle, busy
// stays low in normal streaming.
module rgb_to_hsl_8bit import rhsl_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [4*ChanW-1:0] pixel_i,
  output logic               valid_o,
  output logic [ChanW-1:0]   hue_o,
  output logic [ChanW-1:0]   saturation_o,
  output logic [ChanW-1:0]   lightness_o,
  output logic [ChanW-1:0]   alpha_out_o
);

  logic       fe_valid, q_full, q_valid;
  rhsl_item_t fe_item, q_item;

  // intake and classification
  rhsl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .pixel_i (pixel_i),
    .ready_i (!q_full),
    .busy    (busy),
    .valid_o (fe_valid),
    .item_o  (fe_item)
  );

  // decoupling queue; the back end takes an item every cycle one is there
  rhsl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .item_i  (fe_item),
    .full_o  (q_full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // dividers and output register
  rhsl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .item_i       (q_item),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .lightness_o  (lightness_o),
    .alpha_out_o  (alpha_out_o)
  );

`ifndef SYNTHESIS
  // the back end never stalls, so the front end never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the back end drains every cycle");

  // every accepted pixel yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##13 valid_o)
    else $error("result missing 13 cycles after an accepted pixel");

  // no result without an accepted pixel at the matching edge
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 13))
    else $error("result without a matching accepted pixel");

  // zero saturation only comes from grey, which also has zero hue
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturation_o == '0 |-> hue_o == '0)
    else $error("zero saturation with nonzero hue");
`endif

endmodule

// ===== design/rhsl_front.sv =====
//----------------------------------------------------------------------------
// rhsl_front: pixel intake and classification
// Two register stages: the first finds the largest and smallest channel and
// the sextant, the second forms lightness and both divider operands.
//----------------------------------------------------------------------------
module rhsl_front import rhsl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [4*ChanW-1:0]  pixel_i,
  input  logic                ready_i,
  output logic                busy,
  output logic                valid_o,
  output rhsl_item_t          item_o
);

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } rhsl_sel_e;

  // stage handshake
  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign busy     = !s1_ready;
  assign valid_o  = s2_valid_q;

  // stage 1: max, min and sextant
  logic [ChanW-1:0] red, green, blue;
  logic [ChanW-1:0] mx_d, mn_d;
  rhsl_sel_e        sel_d;

  assign red   = pixel_i[ChanW-1:0];
  assign green = pixel_i[2*ChanW-1:ChanW];
  assign blue  = pixel_i[3*ChanW-1:2*ChanW];

  always_comb begin
    // ties: red wins over green, green over blue
    if (red >= green && red >= blue) begin
      sel_d = SEL_RED;
      mx_d  = red;
    end else if (green >= blue) begin
      sel_d = SEL_GREEN;
      mx_d  = green;
    end else begin
      sel_d = SEL_BLUE;
      mx_d  = blue;
    end
    mn_d = red;
    if (green < mn_d) mn_d = green;
    if (blue < mn_d) mn_d = blue;
  end

  logic [ChanW-1:0] r_q, g_q, b_q, a_q, mx_q, mn_q;
  rhsl_sel_e        sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && s1_ready) begin
      r_q   <= red;
      g_q   <= green;
      b_q   <= blue;
      a_q   <= pixel_i[4*ChanW-1:3*ChanW];
      mx_q  <= mx_d;
      mn_q  <= mn_d;
      sel_q <= sel_d;
    end
  end

  // stage 2: lightness and divider operands
  logic [ChanW-1:0] diff;
  logic [ChanW:0]   sum;
  logic [ChanW:0]   sat_base;
  logic [SxtW-1:0]  d6, sxt;
  rhsl_item_t       item_d, item_q;

  assign diff = mx_q - mn_q;
  assign sum  = {1'b0, mx_q} + {1'b0, mn_q};
  assign d6   = (SxtW'(diff) << 2) + (SxtW'(diff) << 1);

  // sextant numerator, in units of d
  always_comb begin
    unique case (sel_q)
      SEL_RED: begin
        if (g_q < b_q) begin
          sxt = d6 - (SxtW'(b_q) - SxtW'(g_q));
        end else begin
          sxt = SxtW'(g_q) - SxtW'(b_q);
        end
      end
      SEL_GREEN: sxt = (SxtW'(diff) << 1) + SxtW'(b_q) - SxtW'(r_q);
      SEL_BLUE:  sxt = (SxtW'(diff) << 2) + SxtW'(r_q) - SxtW'(g_q);
      default:   sxt = '0;
    endcase
  end

  // saturation divides by sum, or by 512 - sum in the upper half
  assign sat_base = (sum > (ChanW+1)'(256)) ?
                    (ChanW+1)'(11'd512 - 11'(sum)) : sum;

  always_comb begin
    item_d.hue_num   = (NumW'(sxt) << ScaleSh) + NumW'(d6);
    item_d.hue_den   = DenW'(d6) << 1;
    item_d.sat_num   = (NumW'(diff) << ScaleSh) + NumW'(sat_base);
    item_d.sat_den   = DenW'(sat_base) << 1;
    item_d.grey      = (diff == '0);
    item_d.lightness = ChanW'((10'(sum) + 10'd1) >> 1);
    item_d.alpha     = a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== design/rhsl_queue.sv =====
//----------------------------------------------------------------------------
// rhsl_queue: short item queue between front end and back end
// Circular buffer with a fill count; push and pop may happen together.
//----------------------------------------------------------------------------
module rhsl_queue import rhsl_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rhsl_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output rhsl_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rhsl_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // fill count
  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + CntW'(1);
    if (pop && !push) count_d = count_q - CntW'(1);
  end

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    ptr_inc = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/rhsl_div.sv =====
//----------------------------------------------------------------------------
// rhsl_div: pipelined restoring divider
// One quotient bit per stage, most significant first; the dividend must be
// below the divisor times 2**QuoW.
//----------------------------------------------------------------------------
module rhsl_div import rhsl_pkg::*; (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [NumW-1:0] rem_q [QuoW-1];
  logic [DenW-1:0] den_q [QuoW-1];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int unsigned Sh = QuoW - 1 - i;

    logic [NumW-1:0] rem_in, trial;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            take;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // compare against the divisor aligned to this bit
    assign trial = NumW'(den_in) << Sh;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      quo_q[i] <= take ? (quo_in | (QuoW'(1) << Sh)) : quo_in;
    end

    if (i < QuoW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[i] <= take ? (rem_in - trial) : rem_in;
        den_q[i] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

// ===== design/rhsl_back.sv =====
//----------------------------------------------------------------------------
// rhsl_back: divider back end
// Runs hue and saturation through two divider pipelines, carries lightness,
// alpha and the grey flag alongside, then clamps into the output register.
//----------------------------------------------------------------------------
module rhsl_back import rhsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rhsl_item_t       item_i,
  output logic             valid_o,
  output logic [ChanW-1:0] hue_o,
  output logic [ChanW-1:0] saturation_o,
  output logic [ChanW-1:0] lightness_o,
  output logic [ChanW-1:0] alpha_out_o
);

  typedef struct packed {
    logic             grey;
    logic [ChanW-1:0] lightness;
    logic [ChanW-1:0] alpha;
  } rhsl_side_t;

  logic [QuoW-1:0] hue_quo, sat_quo;

  rhsl_div u_hue_div (
    .clk_i (clk_i),
    .num_i (item_i.hue_num),
    .den_i (item_i.hue_den),
    .quo_o (hue_quo)
  );

  rhsl_div u_sat_div (
    .clk_i (clk_i),
    .num_i (item_i.sat_num),
    .den_i (item_i.sat_den),
    .quo_o (sat_quo)
  );

  // side line, aligned with the divider stages
  logic [QuoW-1:0] vld_q;
  rhsl_side_t      side_q [QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QuoW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{grey: item_i.grey, lightness: item_i.lightness, alpha: item_i.alpha};
    for (int i = 1; i < QuoW; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // clamp to 255; grey pixels have no hue or saturation
  function automatic logic [ChanW-1:0] clamp(input logic [QuoW-1:0] q, input logic grey);
    if (grey) begin
      clamp = '0;
    end else if (q[QuoW-1]) begin
      clamp = '1;
    end else begin
      clamp = q[ChanW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o        <= clamp(hue_quo, side_q[QuoW-1].grey);
    saturation_o <= clamp(sat_quo, side_q[QuoW-1].grey);
    lightness_o  <= side_q[QuoW-1].lightness;
    alpha_out_o  <= side_q[QuoW-1].alpha;
  end

endmodule

// ===== tb/rgb_to_hsl_8bit_tb.sv =====
//----------------------------------------------------------------------------
// rgb_to_hsl_8bit_tb: self-checking bench for the RGB to HSL converter
// Streams packed pixels through the start/busy handshake. A directed table
// covers extremes, grey, ties and clamping, then random pixels follow.
// Every result strobe is compared field by field, in order, with its expected value.
//----------------------------------------------------------------------------
module rgb_to_hsl_8bit_tb;
  import rhsl_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int NumDir     = 20;

  // one converted pixel
  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] light;
    logic [ChanW-1:0] alpha;
  } hsl_t;

  // directed row: pixel, plus a hand-computed result where known is set
  typedef struct packed {
    logic [4*ChanW-1:0] pixel;
    logic               known;
    hsl_t               want;
  } dir_row_t;

  // pixel layout: alpha, blue, green, red
  dir_row_t dir_rows [NumDir] = '{
    '{32'h0000_0000, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h00}},  // black
    '{32'hFFFF_FFFF, 1'b1, '{8'd0,   8'd0,   8'd255, 8'hFF}},  // white
    '{32'h8080_8080, 1'b1, '{8'd0,   8'd0,   8'd128, 8'h80}},  // mid grey
    '{32'h0000_00FF, 1'b1, '{8'd0,   8'd255, 8'd128, 8'h00}},  // pure red
    '{32'h0000_FF00, 1'b1, '{8'd85,  8'd255, 8'd128, 8'h00}},  // pure green
    '{32'h00FF_0000, 1'b1, '{8'd171, 8'd255, 8'd128, 8'h00}},  // pure blue
    '{32'h0001_00FF, 1'b1, '{8'd255, 8'd255, 8'd128, 8'h00}},  // hue clamps
    '{32'hFF00_FFFF, 1'b0, '0},  // red/green tie
    '{32'h00FF_FF00, 1'b0, '0},  // green/blue tie
    '{32'h00FF_00FF, 1'b0, '0},  // red/blue tie
    '{32'h00FE_FFFF, 1'b0, '0},  // bright, tiny spread
    '{32'h0080_40C0, 1'b0, '0},  // max+min just at 256
    '{32'h0080_40C1, 1'b0, '0},  // max+min just above 256
    '{32'h0000_0001, 1'b0, '0},  // near black, saturation clamps
    '{32'h00FE_FEFF, 1'b0, '0},  // near white
    '{32'h55AA_55AA, 1'b0, '0},
    '{32'hAA55_AA55, 1'b0, '0},
    '{32'h0010_3050, 1'b0, '0},  // red largest, green above blue
    '{32'h00F0_1020, 1'b0, '0},  // blue largest
    '{32'h0040_10F0, 1'b0, '0}   // red largest, green below blue
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [4*ChanW-1:0] pixel_i;
  logic               valid_o;
  logic [ChanW-1:0]   hue_o;
  logic [ChanW-1:0]   saturation_o;
  logic [ChanW-1:0]   lightness_o;
  logic [ChanW-1:0]   alpha_out_o;

  // travels with each item so the checker knows which expectation to use
  logic row_known;
  hsl_t row_want;

  hsl_t hsl_exp_q [$];
  bit   idle_en;
  int   fail_cnt   = 0;
  int   item_cnt   = 0;
  int   result_cnt = 0;
  int   quiet_cnt  = 0;
  int   grey_cnt   = 0;
  int   tie_cnt    = 0;
  int   rail_cnt   = 0;

  rgb_to_hsl_8bit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_i),
    .valid_o     (valid_o),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .lightness_o (lightness_o),
    .alpha_out_o (alpha_out_o)
  );

  always #1 clk_i = ~clk_i;

  // rounded quotient, half up
  function automatic logic [QuoW-1:0] round_quot(logic [NumW-1:0] num,
                                                 logic [DenW-1:0] den);
    return QuoW'((2 * num + den) / (2 * den));
  endfunction

  function automatic logic [ChanW-1:0] clamp_byte(logic [QuoW-1:0] q);
    return (q > 255) ? 8'd255 : q[ChanW-1:0];
  endfunction

  // expected hue, saturation, lightness and alpha of one pixel
  function automatic hsl_t predict_hsl(logic [4*ChanW-1:0] pix);
    logic [ChanW-1:0] r, g, b, mx, mn, d;
    logic [ChanW:0]   sum;
    logic [SxtW-1:0]  sxt;
    hsl_t             res;
    r = pix[7:0];
    g = pix[15:8];
    b = pix[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    d = mx - mn;
    res.alpha = pix[31:24];
    res.light = ChanW'((sum + 9'd1) >> 1);
    res.hue = '0;
    res.sat = '0;
    // grey leaves hue and saturation at zero
    if (d != 0) begin
      res.sat = clamp_byte(round_quot(NumW'(256 * d),
                                      DenW'((sum > 256) ? 512 - sum : sum)));
      // ties resolve red, then green, then blue
      if (mx == r) begin
        if (g < b) sxt = SxtW'(6 * d - (b - g));
        else sxt = SxtW'(g - b);
      end else if (mx == g) begin
        sxt = SxtW'(2 * d + b - r);
      end else begin
        sxt = SxtW'(4 * d + r - g);
      end
      res.hue = clamp_byte(round_quot(NumW'(256 * sxt), DenW'(6 * d)));
    end
    return res;
  endfunction

  // channel within a few counts of base
  function automatic logic [ChanW-1:0] near_chan(logic [ChanW-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[ChanW-1:0];
  endfunction

  // channel from the range rails and the midpoint
  function automatic logic [ChanW-1:0] rail_chan();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // offer one item, with an occasional gap first
  task automatic send_pixel(input logic [4*ChanW-1:0] pix, input logic known,
                            input hsl_t want);
    if (idle_en && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    start     <= 1'b1;
    pixel_i   <= pix;
    row_known <= known;
    row_want  <= want;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending until every pending result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (hsl_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker, expectation capture and watchdog
  always @(posedge clk_i) begin : check_results
    hsl_t want;
    if (rst_ni) begin
      if (valid_o) begin
        result_cnt++;
        if (hsl_exp_q.size() == 0) begin
          $error("unexpected result: hue %0d sat %0d light %0d alpha %0d",
                 hue_o, saturation_o, lightness_o, alpha_out_o);
          fail_cnt++;
        end else begin
          want = hsl_exp_q.pop_front();
          if (hue_o !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, hue_o);
            fail_cnt++;
          end
          if (saturation_o !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, saturation_o);
            fail_cnt++;
          end
          if (lightness_o !== want.light) begin
            $error("lightness: expected %0d, got %0d", want.light, lightness_o);
            fail_cnt++;
          end
          if (alpha_out_o !== want.alpha) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha, alpha_out_o);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        hsl_exp_q.push_back(row_known ? row_want : predict_hsl(pixel_i));
        item_cnt++;
      end
      if (valid_o || (start && !busy)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= QuietLimit) begin
          $display("watchdog: no handshake for %0d cycles, %0d results pending",
                   quiet_cnt, hsl_exp_q.size());
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [ChanW-1:0]   a, c, x;
    logic [4*ChanW-1:0] pix;
    int                 seg_len;
    rst_ni    = 1'b0;
    start     = 1'b0;
    pixel_i   = '0;
    row_known = 1'b0;
    row_want  = '0;
    idle_en   = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumDir; i++) begin
      send_pixel(dir_rows[i].pixel, dir_rows[i].known, dir_rows[i].want);
    end
    drain_results();

    // random pixels; middle segment streams back to back
    for (int seg = 0; seg < 3; seg++) begin
      idle_en = (seg != 1);
      seg_len = (seg == 1) ? 350 : 400;
      for (int i = 0; i < seg_len; i++) begin
        a = ChanW'($urandom_range(255));
        case ($urandom_range(9))
          0, 1, 2, 3: pix = $urandom;
          4, 5: begin
            c = ChanW'($urandom_range(255));
            pix = {a, near_chan(c), near_chan(c), near_chan(c)};
            grey_cnt++;
          end
          6, 7: begin
            c = ChanW'($urandom_range(255));
            x = ChanW'($urandom_range(255));
            case ($urandom_range(2))
              0: pix = {a, x, c, c};
              1: pix = {a, c, c, x};
              default: pix = {a, c, x, c};
            endcase
            tie_cnt++;
          end
          default: begin
            pix = {a, rail_chan(), rail_chan(), rail_chan()};
            rail_cnt++;
          end
        endcase
        send_pixel(pix, 1'b0, '0);
      end
      if (seg == 1) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (hsl_exp_q.size() != 0) begin
      $error("%0d results never arrived", hsl_exp_q.size());
      fail_cnt++;
    end

    $display("run: %0d pixels in, %0d results checked, %0d mismatches",
             item_cnt, result_cnt, fail_cnt);
    $display("mix: %0d table rows, %0d near-grey, %0d tied, %0d rail-valued",
             NumDir, grey_cnt, tie_cnt, rail_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
